>>> rtl/loss_reduction_unit_macros.svh
// Assertion helpers shared by the loss reduction unit.
// Both sample on aclk and are off while aresetn is low.
`ifndef LOSS_REDUCTION_UNIT_MACROS_SVH
`define LOSS_REDUCTION_UNIT_MACROS_SVH

// Same-cycle implication
`define LRU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("loss_reduction_unit: check failed");

// Next-cycle implication
`define LRU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("loss_reduction_unit: check failed");

`endif

>>> rtl/lru_pkg.sv
`timescale 1ns / 1ps

package lru_pkg;

    // Loss modes
    localparam logic [1:0] MODE_HALF_SSQ = 2'd0;
    localparam logic [1:0] MODE_ROOT_SSQ = 2'd1;
    localparam logic [1:0] MODE_CE       = 2'd2;
    localparam logic [1:0] MODE_BCE      = 2'd3;

    localparam int COUNT_W = 16;

    // Fixed-point constants
    localparam logic        [23:0] LN2_Q24   = 24'd11629080;
    localparam logic signed [17:0] ONE_Q14   = 18'sd16384;
    localparam logic signed [17:0] DELTA_CE  = 18'sd0;
    localparam logic signed [17:0] DELTA_BCE = 18'sd2;

    // Iteration counts of the sequential units
    localparam logic [5:0] LN_STEPS   = 6'd24;
    localparam logic [5:0] SQRT_STEPS = 6'd25;
    localparam logic [5:0] DIV_STEPS  = 6'd36;

    typedef struct packed {
        logic signed [15:0] prediction;
        logic signed [15:0] target;
        logic               last_element;
    } lru_in_t;

    typedef struct packed {
        logic [31:0] loss_value;
        logic        saturated;
    } lru_out_t;

    typedef struct packed {
        logic load_item;
        logic sq;
        logic ln_init;
        logic ln_sel;
        logic ln_step;
        logic ln_mul;
        logic ln_term;
        logic acc;
        logic fin_init;
        logic sqrt_step;
        logic div_step;
        logic out_load;
    } lru_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       last;
    } lru_stat_t;

endpackage

>>> rtl/lru_datapath.sv
`timescale 1ns / 1ps

module lru_datapath #(
    parameter int MAX_ELEMENTS   = 65535,
    parameter int LOG_TABLE_BITS = 10
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_wr_data,
    input  lru_pkg::lru_in_t  s_data,
    input  lru_pkg::lru_cmd_t cmd,
    output lru_pkg::lru_stat_t stat,
    output lru_pkg::lru_out_t m_data
);
    import lru_pkg::*;

    localparam int KW = COUNT_W + LOG_TABLE_BITS + 1;

    logic [1:0]                mode_reg;
    logic signed [15:0]        p_reg;
    logic signed [15:0]        t_reg;
    logic                      last_reg;
    logic signed [47:0]        sum_reg, sum_next;
    logic [COUNT_W-1:0]        count_reg, count_next;
    logic                      ovf_reg, ovf_next;
    logic signed [39:0]        term_reg, term_next;
    logic [30:0]               y_reg, y_next;
    logic [23:0]               f_reg, f_next;
    logic [4:0]                e_reg, e_next;
    logic [51:0]               mag_reg;
    logic                      neg_reg;
    logic [49:0]               sq_v_reg, sq_v_next;
    logic [27:0]               sq_rem_reg, sq_rem_next;
    logic [24:0]               sq_root_reg, sq_root_next;
    logic [35:0]               dv_n_reg, dv_n_next;
    logic [COUNT_W-1:0]        dv_rem_reg, dv_rem_next;
    logic [35:0]               dv_q_reg, dv_q_next;
    lru_out_t                  m_data_reg, m_data_next;

    // Log argument: prediction plus delta, or one minus prediction plus delta
    logic signed [17:0]        ln_arg;
    logic [15:0]               ln_ua;
    logic [3:0]                e_raw;
    logic [15:0]               ln_r;
    logic [KW-1:0]             ktmp;
    logic [LOG_TABLE_BITS:0]   kr;
    logic [30:0]               y_init;
    logic [4:0]                e_init;

    always_comb begin
        if (cmd.ln_sel) begin
            ln_arg = ONE_Q14 - 18'(p_reg) + DELTA_BCE;
        end else if (mode_reg == MODE_CE) begin
            ln_arg = 18'(p_reg) + DELTA_CE;
        end else begin
            ln_arg = 18'(p_reg) + DELTA_BCE;
        end
        if (ln_arg < 18'sd1) begin
            ln_ua = 16'd1;
        end else if (ln_arg[17:16] != 2'b00) begin
            ln_ua = 16'hFFFF;
        end else begin
            ln_ua = ln_arg[15:0];
        end
        // Find the octave
        e_raw = 4'd0;
        for (int i = 1; i < 16; i++) begin
            if (ln_ua[i]) begin
                e_raw = 4'(i);
            end
        end
        ln_r = ln_ua - (16'd1 << e_raw);
        // Round the mantissa fraction to the table resolution
        ktmp = {ln_r, {(LOG_TABLE_BITS+1){1'b0}}} >> e_raw;
        kr   = {1'b0, ktmp[LOG_TABLE_BITS:1]} + {{LOG_TABLE_BITS{1'b0}}, ktmp[0]};
        if (kr[LOG_TABLE_BITS]) begin
            e_init = {1'b0, e_raw} + 5'd1;
            y_init = {1'b1, {LOG_TABLE_BITS{1'b0}}, {(30-LOG_TABLE_BITS){1'b0}}};
        end else begin
            e_init = {1'b0, e_raw};
            y_init = {1'b1, kr[LOG_TABLE_BITS-1:0], {(30-LOG_TABLE_BITS){1'b0}}};
        end
    end

    // One squaring step of the log2 fraction
    logic [61:0] y_sq;
    logic [31:0] y_sh;
    assign y_sq = y_reg * y_reg;
    assign y_sh = y_sq[61:30];

    // Scale log2 by ln2
    logic [5:0]         e_off;
    logic signed [29:0] l2;
    logic [29:0]        l2_abs;
    assign e_off  = 6'(e_reg) - 6'd14;
    assign l2     = {e_off, f_reg};
    assign l2_abs = l2[29] ? 30'(-l2) : 30'(l2);

    // Round ln to Q6.14 and weight by the target
    logic [52:0]        mag_rnd;
    logic [18:0]        ln_mag;
    logic signed [19:0] ln_val;
    logic signed [16:0] coef;
    logic signed [36:0] prod;
    assign mag_rnd = {1'b0, mag_reg} + (53'd1 << 33);
    assign ln_mag  = mag_rnd[52:34];
    assign ln_val  = neg_reg ? -$signed({1'b0, ln_mag}) : $signed({1'b0, ln_mag});
    assign coef    = cmd.ln_sel ? ($signed({t_reg[15], t_reg}) - 17'(ONE_Q14))
                                : -$signed({t_reg[15], t_reg});
    assign prod    = coef * ln_val;

    // Squared error term
    logic signed [16:0] diff;
    logic signed [33:0] dsq;
    assign diff = $signed({p_reg[15], p_reg}) - $signed({t_reg[15], t_reg});
    assign dsq  = diff * diff;

    // Saturating accumulate
    logic signed [48:0] acc_sum;
    assign acc_sum = 49'(sum_reg) + 49'(term_reg);

    // Final reduction inputs
    logic [46:0] us;
    logic [47:0] half_rnd;
    logic [47:0] div_num;
    assign us       = sum_reg[46:0];
    assign half_rnd = {1'b0, us} + 48'd4096;
    assign div_num  = {1'b0, us} + 48'({count_reg, 11'b0});

    // Sqrt and divide steps
    logic [27:0]        sq_rem2;
    logic [27:0]        sq_trial;
    logic [COUNT_W:0]   dv_rem2;
    assign sq_rem2  = {sq_rem_reg[25:0], sq_v_reg[49:48]};
    assign sq_trial = {1'b0, sq_root_reg, 2'b01};
    assign dv_rem2  = {dv_rem_reg, dv_n_reg[35]};

    logic [35:0] val;
    logic        val_big;

    always_comb begin
        term_next    = term_reg;
        y_next       = y_reg;
        f_next       = f_reg;
        e_next       = e_reg;
        sq_v_next    = sq_v_reg;
        sq_rem_next  = sq_rem_reg;
        sq_root_next = sq_root_reg;
        dv_n_next    = dv_n_reg;
        dv_rem_next  = dv_rem_reg;
        dv_q_next    = dv_q_reg;
        sum_next     = sum_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        m_data_next  = m_data_reg;
        val          = 36'd0;
        val_big      = 1'b0;

        if (cmd.sq) begin
            term_next = 40'(dsq);
        end
        if (cmd.ln_term) begin
            term_next = (cmd.ln_sel ? term_reg : 40'sd0) + 40'(prod);
        end
        if (cmd.ln_init) begin
            y_next = y_init;
            e_next = e_init;
            f_next = 24'd0;
        end
        if (cmd.ln_step) begin
            if (y_sh[31]) begin
                y_next = y_sh[31:1];
                f_next = {f_reg[22:0], 1'b1};
            end else begin
                y_next = y_sh[30:0];
                f_next = {f_reg[22:0], 1'b0};
            end
        end
        if (cmd.acc) begin
            if (acc_sum[48] != acc_sum[47]) begin
                sum_next = acc_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
                ovf_next = 1'b1;
            end else begin
                sum_next = acc_sum[47:0];
            end
            if (count_reg < COUNT_W'(MAX_ELEMENTS)) begin
                count_next = count_reg + 1'b1;
            end else begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.fin_init) begin
            sq_v_next    = {us, 3'b000};
            sq_rem_next  = 28'd0;
            sq_root_next = 25'd0;
            dv_n_next    = div_num[47:12];
            dv_rem_next  = '0;
            dv_q_next    = 36'd0;
        end
        if (cmd.sqrt_step) begin
            sq_v_next = {sq_v_reg[47:0], 2'b00};
            if (sq_rem2 >= sq_trial) begin
                sq_rem_next  = sq_rem2 - sq_trial;
                sq_root_next = {sq_root_reg[23:0], 1'b1};
            end else begin
                sq_rem_next  = sq_rem2;
                sq_root_next = {sq_root_reg[23:0], 1'b0};
            end
        end
        if (cmd.div_step) begin
            dv_n_next = {dv_n_reg[34:0], 1'b0};
            if (dv_rem2 >= {1'b0, count_reg}) begin
                dv_rem_next = COUNT_W'(dv_rem2 - {1'b0, count_reg});
                dv_q_next   = {dv_q_reg[34:0], 1'b1};
            end else begin
                dv_rem_next = dv_rem2[COUNT_W-1:0];
                dv_q_next   = {dv_q_reg[34:0], 1'b0};
            end
        end
        // Pick the result, clamp it and clear the vector state
        case (mode_reg)
            MODE_HALF_SSQ: val = 36'(half_rnd[47:13]);
            MODE_ROOT_SSQ: val = 36'(sq_root_reg);
            default:       val = dv_q_reg;
        endcase
        val_big = (val[35:32] != 4'd0);
        if (cmd.out_load) begin
            if (sum_reg[47]) begin
                m_data_next.loss_value = 32'd0;
            end else if (val_big) begin
                m_data_next.loss_value = 32'hFFFF_FFFF;
            end else begin
                m_data_next.loss_value = val[31:0];
            end
            m_data_next.saturated = ovf_reg | sum_reg[47] | val_big;
            sum_next   = '0;
            count_next = '0;
            ovf_next   = 1'b0;
        end
    end

    // Control and vector state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_HALF_SSQ;
            sum_reg   <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
            sum_reg   <= sum_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            p_reg    <= s_data.prediction;
            t_reg    <= s_data.target;
            last_reg <= s_data.last_element;
        end
        if (cmd.ln_mul) begin
            mag_reg <= l2_abs[27:0] * LN2_Q24;
            neg_reg <= l2[29];
        end
        term_reg    <= term_next;
        y_reg       <= y_next;
        f_reg       <= f_next;
        e_reg       <= e_next;
        sq_v_reg    <= sq_v_next;
        sq_rem_reg  <= sq_rem_next;
        sq_root_reg <= sq_root_next;
        dv_n_reg    <= dv_n_next;
        dv_rem_reg  <= dv_rem_next;
        dv_q_reg    <= dv_q_next;
        m_data_reg  <= m_data_next;
    end

    assign stat.mode = mode_reg;
    assign stat.last = last_reg;
    assign m_data    = m_data_reg;

endmodule

>>> rtl/lru_ctrl.sv
`timescale 1ns / 1ps
`include "loss_reduction_unit_macros.svh"

module lru_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  lru_pkg::lru_stat_t stat,
    output lru_pkg::lru_cmd_t  cmd
);
    import lru_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SQ      = 4'd1;
    localparam logic [3:0] S_LN_INIT = 4'd2;
    localparam logic [3:0] S_LN_SQ   = 4'd3;
    localparam logic [3:0] S_LN_MUL  = 4'd4;
    localparam logic [3:0] S_LN_TERM = 4'd5;
    localparam logic [3:0] S_ACC     = 4'd6;
    localparam logic [3:0] S_FIN     = 4'd7;
    localparam logic [3:0] S_SQRT    = 4'd8;
    localparam logic [3:0] S_DIV     = 4'd9;
    localparam logic [3:0] S_OUT     = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       ln_pass_reg, ln_pass_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;

    // Sequence one item, then the end-of-vector reduction
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        ln_pass_next = ln_pass_reg;
        cmd          = '0;
        cmd.ln_sel   = ln_pass_reg;
        s_ready      = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    ln_pass_next  = 1'b0;
                    if (stat.mode == MODE_HALF_SSQ || stat.mode == MODE_ROOT_SSQ) begin
                        state_next = S_SQ;
                    end else begin
                        state_next = S_LN_INIT;
                    end
                end
            end
            S_SQ: begin
                cmd.sq     = 1'b1;
                state_next = S_ACC;
            end
            S_LN_INIT: begin
                cmd.ln_init = 1'b1;
                cnt_next    = 6'd0;
                state_next  = S_LN_SQ;
            end
            S_LN_SQ: begin
                cmd.ln_step = 1'b1;
                cnt_next    = cnt_reg + 6'd1;
                if (cnt_reg == LN_STEPS - 6'd1) begin
                    state_next = S_LN_MUL;
                end
            end
            S_LN_MUL: begin
                cmd.ln_mul = 1'b1;
                state_next = S_LN_TERM;
            end
            S_LN_TERM: begin
                cmd.ln_term = 1'b1;
                if (stat.mode == MODE_BCE && !ln_pass_reg) begin
                    ln_pass_next = 1'b1;
                    state_next   = S_LN_INIT;
                end else begin
                    state_next = S_ACC;
                end
            end
            S_ACC: begin
                cmd.acc    = 1'b1;
                state_next = stat.last ? S_FIN : S_IDLE;
            end
            S_FIN: begin
                cmd.fin_init = 1'b1;
                cnt_next     = 6'd0;
                case (stat.mode)
                    MODE_HALF_SSQ: state_next = S_OUT;
                    MODE_ROOT_SSQ: state_next = S_SQRT;
                    default:       state_next = S_DIV;
                endcase
            end
            S_SQRT: begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 6'd1;
                if (cnt_reg == SQRT_STEPS - 6'd1) begin
                    state_next = S_OUT;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == DIV_STEPS - 6'd1) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                // Hold until the output register is free
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result beat valid
    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= 6'd0;
            ln_pass_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            ln_pass_reg <= ln_pass_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    `LRU_ASSERT_NXT(a_out_to_idle, (state_reg == S_OUT) && out_free, (state_reg == S_IDLE) && m_valid_reg)
    `LRU_ASSERT_NXT(a_bce_second_log, (state_reg == S_LN_TERM) && (stat.mode == MODE_BCE) && !ln_pass_reg, state_reg == S_LN_INIT)
    `LRU_ASSERT_NXT(a_square_path, s_valid && s_ready && (stat.mode == MODE_HALF_SSQ || stat.mode == MODE_ROOT_SSQ), state_reg == S_SQ)

endmodule

>>> rtl/loss_reduction_unit.sv
`timescale 1ns / 1ps
// Each beat takes the squared-error path in the square modes, or the log path with the
// 24-step log2 squaring loop: once for cross entropy, twice for binary cross entropy.
// One beat is in work at a time; the next is taken once the previous one is summed or,
// after a last beat, once any bit-serial root or mean divide is done and output loads.
// Reset (aresetn low, synchronous) clears the mode, sum, count, flags and output valid.
module loss_reduction_unit #(
    parameter int MAX_ELEMENTS   = 65535,
    parameter int LOG_TABLE_BITS = 10
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  lru_pkg::lru_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output lru_pkg::lru_out_t m_data
);
    import lru_pkg::*;

    lru_cmd_t  cmd;
    lru_stat_t stat;

    lru_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    lru_datapath #(
        .MAX_ELEMENTS   (MAX_ELEMENTS),
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .cmd         (cmd),
        .stat        (stat),
        .m_data      (m_data)
    );

endmodule
